### rtl/btic_pkg.sv
// shared types, constants and codes of the bounded tape interpreter
package btic_pkg;

    // default sizes handed to the top level parameters
    localparam int TAPE_CELLS_DEF    = 256;
    localparam int PROGRAM_DEPTH_DEF = 1024;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int SYM_W    = 8;
    localparam int INVAL_W  = 16;
    localparam int STATUS_W = 4;
    localparam int PC_OUT_W = 11;

    // largest value a tape cell holds
    localparam logic [SYM_W-1:0] CELL_MAX = 8'hFF;

    // program symbols
    localparam logic [SYM_W-1:0] SYM_RIGHT = 8'h3E;  // '>'
    localparam logic [SYM_W-1:0] SYM_LEFT  = 8'h3C;  // '<'
    localparam logic [SYM_W-1:0] SYM_INC   = 8'h2B;  // '+'
    localparam logic [SYM_W-1:0] SYM_DEC   = 8'h2D;  // '-'
    localparam logic [SYM_W-1:0] SYM_PUT   = 8'h2E;  // '.'
    localparam logic [SYM_W-1:0] SYM_GET   = 8'h2C;  // ','
    localparam logic [SYM_W-1:0] SYM_OPEN  = 8'h5B;  // '['
    localparam logic [SYM_W-1:0] SYM_CLOSE = 8'h5D;  // ']'

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD    = 2'd0,
        REQ_STEP    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_ERASE   = 2'd3
    } req_t;

    // answer codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 4'd0,
        ST_ENDED   = 4'd1,
        ST_BRACKET = 4'd2,
        ST_ABOVE   = 4'd3,
        ST_BELOW   = 4'd4,
        ST_OVER    = 4'd5,
        ST_UNDER   = 4'd6,
        ST_BADIN   = 4'd7,
        ST_FULL    = 4'd8,
        ST_LATCHED = 4'd9
    } status_t;

    // datapath operation issued by the controller each cycle
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CAPTURE,
        OP_DISPATCH,
        OP_EXEC,
        OP_SCAN_ADDR,
        OP_SCAN_TEST,
        OP_PUBLISH,
        OP_CLEAR
    } dp_op_t;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_EXEC,
        S_SCAN_ADDR,
        S_SCAN_TEST,
        S_FINISH
    } ctrl_state_t;

    // datapath status seen by the controller
    typedef struct packed {
        req_t req;
        logic pre_stop;
        logic need_scan;
        logic scan_end;
        logic scan_hit;
        logic clear_last;
        logic res_free;
    } dp_status_t;

endpackage

### rtl/bounded_tape_interpreter_core.sv
// top level of the bounded tape interpreter
//
// channel   direction  handshake              payload
// request   in         in_valid / in_stall    req_type, program_symbol, in_value
// result    out        res_valid / res_stall  status, out_valid, out_byte, program_counter
//
// one request at a time, one result per request, held in an output register
// load, erase, step that stops early: dispatch, then finish publishes the result
// plain step: dispatch, execute, then finish publishes the result
// bracket jump: scan-address and scan-test per symbol walked; no partner ends in scan-address
// restart: dispatch and finish, then the clear state zeroes the tape; reset zeroes it too
// a stalled result holds; the next request is taken but waits to publish
module bounded_tape_interpreter_core #(
    parameter int TAPE_CELLS    = btic_pkg::TAPE_CELLS_DEF,
    parameter int PROGRAM_DEPTH = btic_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [btic_pkg::REQ_W-1:0]       req_type,
    input  logic [btic_pkg::SYM_W-1:0]       program_symbol,
    input  logic [btic_pkg::INVAL_W-1:0]     in_value,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [btic_pkg::STATUS_W-1:0]    status,
    output logic                             out_valid,
    output logic [btic_pkg::SYM_W-1:0]       out_byte,
    output logic [btic_pkg::PC_OUT_W-1:0]    program_counter
);

    import btic_pkg::*;

    dp_op_t     op;
    dp_status_t stat;

    // sequencer
    btic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .stat     (stat)
    );

    // state, memories and result register
    btic_dp #(
        .TAPE_CELLS    (TAPE_CELLS),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .op              (op),
        .stat            (stat),
        .req_type        (req_type),
        .program_symbol  (program_symbol),
        .in_value        (in_value),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status          (status),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .program_counter (program_counter)
    );

endmodule

### rtl/btic_ram.sv
// generic single write port ram with registered read
module btic_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/btic_ctrl.sv
// sequencing state machine of the bounded tape interpreter
module btic_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output btic_pkg::dp_op_t       op,
    input  btic_pkg::dp_status_t   stat
);

    import btic_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register, reset starts with a tape clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and datapath operation
    always_comb
    begin
        state_next = state_reg;
        op         = OP_IDLE;
        unique case (state_reg)
            S_CLEAR:
            begin
                op = OP_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                op = OP_DISPATCH;
                if (stat.req == REQ_STEP && !stat.pre_stop)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_EXEC:
            begin
                op         = OP_EXEC;
                state_next = stat.need_scan ? S_SCAN_ADDR : S_FINISH;
            end
            S_SCAN_ADDR:
            begin
                op         = OP_SCAN_ADDR;
                state_next = stat.scan_end ? S_FINISH : S_SCAN_TEST;
            end
            S_SCAN_TEST:
            begin
                op         = OP_SCAN_TEST;
                state_next = stat.scan_hit ? S_FINISH : S_SCAN_ADDR;
            end
            S_FINISH:
            begin
                if (stat.res_free)
                begin
                    op         = OP_PUBLISH;
                    state_next = (stat.req == REQ_RESTART) ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### rtl/btic_dp.sv
// registers, memories and command logic of the bounded tape interpreter
module btic_dp #(
    parameter int TAPE_CELLS    = btic_pkg::TAPE_CELLS_DEF,
    parameter int PROGRAM_DEPTH = btic_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  btic_pkg::dp_op_t                 op,
    output btic_pkg::dp_status_t             stat,
    input  logic [btic_pkg::REQ_W-1:0]       req_type,
    input  logic [btic_pkg::SYM_W-1:0]       program_symbol,
    input  logic [btic_pkg::INVAL_W-1:0]     in_value,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [btic_pkg::STATUS_W-1:0]    status,
    output logic                             out_valid,
    output logic [btic_pkg::SYM_W-1:0]       out_byte,
    output logic [btic_pkg::PC_OUT_W-1:0]    program_counter
);

    import btic_pkg::*;

    localparam int PTR_W = $clog2(TAPE_CELLS);
    localparam int PA_W  = $clog2(PROGRAM_DEPTH);
    localparam int LEN_W = $clog2(PROGRAM_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_TOP  = PTR_W'(TAPE_CELLS - 1);
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(PROGRAM_DEPTH);

    // captured request
    req_t                 req_reg, req_next;
    logic [SYM_W-1:0]     sym_reg, sym_next;
    logic [INVAL_W-1:0]   inval_reg, inval_next;

    // architectural state
    logic [LEN_W-1:0]     length_reg, length_next;
    logic                 parity_reg, parity_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [LEN_W-1:0]     rc_reg, rc_next;
    status_t              latched_reg, latched_next;
    logic [PTR_W-1:0]     clr_idx_reg, clr_idx_next;

    // bracket scan
    logic [PA_W-1:0]      scan_pos_reg, scan_pos_next;
    logic [LEN_W-1:0]     scan_depth_reg, scan_depth_next;
    logic                 scan_fwd_reg, scan_fwd_next;

    // pending and registered result
    status_t              pend_status_reg, pend_status_next;
    logic                 pend_ov_reg, pend_ov_next;
    logic [SYM_W-1:0]     pend_ob_reg, pend_ob_next;
    logic                 res_valid_reg, res_valid_next;
    status_t              res_status_reg, res_status_next;
    logic                 res_ov_reg, res_ov_next;
    logic [SYM_W-1:0]     res_ob_reg, res_ob_next;
    logic [PC_OUT_W-1:0]  res_pc_reg, res_pc_next;

    // memory ports
    logic                 prog_we;
    logic [PA_W-1:0]      prog_raddr;
    logic [SYM_W-1:0]     prog_rdata;
    logic                 tape_we;
    logic [PTR_W-1:0]     tape_waddr;
    logic [SYM_W-1:0]     tape_wdata;
    logic [SYM_W-1:0]     tape_rdata;

    // helpers
    logic                 sym_is_bracket;
    logic                 pre_stop;
    logic                 need_scan;
    logic                 scan_end;
    logic                 scan_hit;
    logic                 clear_last;
    logic                 res_free;
    logic [LEN_W-1:0]     rc_inc;
    logic [LEN_W-1:0]     scan_pos_inc;
    logic [PA_W-1:0]      scan_step;
    logic [SYM_W-1:0]     open_sym;
    logic [SYM_W-1:0]     close_sym;
    logic [31:0]          rc_wide;

    // program store
    btic_ram #(
        .DATA_W (SYM_W),
        .DEPTH  (PROGRAM_DEPTH)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_we),
        .waddr (length_reg[PA_W-1:0]),
        .wdata (sym_reg),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    // data tape
    btic_ram #(
        .DATA_W (SYM_W),
        .DEPTH  (TAPE_CELLS)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (ptr_reg),
        .rdata (tape_rdata)
    );

    // status toward the controller
    assign sym_is_bracket = (sym_reg == SYM_OPEN) || (sym_reg == SYM_CLOSE);
    assign pre_stop       = (latched_reg != ST_OK) || parity_reg || (rc_reg >= length_reg);
    assign need_scan      = ((prog_rdata == SYM_OPEN) && (tape_rdata == '0))
                         || ((prog_rdata == SYM_CLOSE) && (tape_rdata != '0));
    assign rc_inc         = rc_reg + LEN_W'(1);
    assign scan_pos_inc   = LEN_W'(scan_pos_reg) + LEN_W'(1);
    assign scan_end       = scan_fwd_reg ? (scan_pos_inc >= length_reg)
                                         : (scan_pos_reg == '0);
    assign scan_step      = scan_fwd_reg ? (scan_pos_reg + PA_W'(1))
                                         : (scan_pos_reg - PA_W'(1));
    assign open_sym       = scan_fwd_reg ? SYM_OPEN : SYM_CLOSE;
    assign close_sym      = scan_fwd_reg ? SYM_CLOSE : SYM_OPEN;
    assign scan_hit       = (prog_rdata == close_sym) && (scan_depth_reg == '0);
    assign clear_last     = (clr_idx_reg == PTR_TOP);
    assign res_free       = !res_valid_reg || !res_stall;
    assign rc_wide        = 32'(rc_reg);

    assign stat.req        = req_reg;
    assign stat.pre_stop   = pre_stop;
    assign stat.need_scan  = need_scan;
    assign stat.scan_end   = scan_end;
    assign stat.scan_hit   = scan_hit;
    assign stat.clear_last = clear_last;
    assign stat.res_free   = res_free;

    // operation decode and next state
    always_comb
    begin
        req_next         = req_reg;
        sym_next         = sym_reg;
        inval_next       = inval_reg;
        length_next      = length_reg;
        parity_next      = parity_reg;
        ptr_next         = ptr_reg;
        rc_next          = rc_reg;
        latched_next     = latched_reg;
        clr_idx_next     = clr_idx_reg;
        scan_pos_next    = scan_pos_reg;
        scan_depth_next  = scan_depth_reg;
        scan_fwd_next    = scan_fwd_reg;
        pend_status_next = pend_status_reg;
        pend_ov_next     = pend_ov_reg;
        pend_ob_next     = pend_ob_reg;
        res_status_next  = res_status_reg;
        res_ov_next      = res_ov_reg;
        res_ob_next      = res_ob_reg;
        res_pc_next      = res_pc_reg;
        res_valid_next   = res_valid_reg && res_stall;
        prog_we          = 1'b0;
        prog_raddr       = rc_reg[PA_W-1:0];
        tape_we          = 1'b0;
        tape_waddr       = ptr_reg;
        tape_wdata       = '0;

        case (op)
            OP_CAPTURE:
            begin
                req_next   = req_t'(req_type);
                sym_next   = program_symbol;
                inval_next = in_value;
            end

            // load, erase and restart finish here; a step runs its checks
            OP_DISPATCH:
            begin
                pend_status_next = ST_OK;
                pend_ov_next     = 1'b0;
                pend_ob_next     = '0;
                unique case (req_reg)
                    REQ_LOAD:
                    begin
                        if (length_reg == LEN_FULL)
                        begin
                            pend_status_next = ST_FULL;
                        end
                        else
                        begin
                            prog_we     = 1'b1;
                            length_next = length_reg + LEN_W'(1);
                            if (sym_is_bracket)
                            begin
                                parity_next = ~parity_reg;
                            end
                        end
                    end
                    REQ_STEP:
                    begin
                        if (latched_reg != ST_OK)
                        begin
                            pend_status_next = ST_LATCHED;
                        end
                        else if (parity_reg)
                        begin
                            latched_next     = ST_BRACKET;
                            pend_status_next = ST_BRACKET;
                        end
                        else if (rc_reg >= length_reg)
                        begin
                            pend_status_next = ST_ENDED;
                        end
                    end
                    REQ_RESTART:
                    begin
                        ptr_next     = '0;
                        rc_next      = '0;
                        latched_next = ST_OK;
                    end
                    REQ_ERASE:
                    begin
                        length_next = '0;
                        parity_next = 1'b0;
                        rc_next     = '0;
                    end
                endcase
            end

            // one command on the fetched symbol and cell
            OP_EXEC:
            begin
                unique case (prog_rdata) inside
                    SYM_RIGHT:
                    begin
                        if (ptr_reg == PTR_TOP)
                        begin
                            latched_next     = ST_ABOVE;
                            pend_status_next = ST_ABOVE;
                        end
                        else
                        begin
                            ptr_next = ptr_reg + PTR_W'(1);
                            rc_next  = rc_inc;
                        end
                    end
                    SYM_LEFT:
                    begin
                        if (ptr_reg == '0)
                        begin
                            latched_next     = ST_BELOW;
                            pend_status_next = ST_BELOW;
                        end
                        else
                        begin
                            ptr_next = ptr_reg - PTR_W'(1);
                            rc_next  = rc_inc;
                        end
                    end
                    SYM_INC:
                    begin
                        if (tape_rdata == CELL_MAX)
                        begin
                            latched_next     = ST_OVER;
                            pend_status_next = ST_OVER;
                        end
                        else
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_rdata + SYM_W'(1);
                            rc_next    = rc_inc;
                        end
                    end
                    SYM_DEC:
                    begin
                        if (tape_rdata == '0)
                        begin
                            latched_next     = ST_UNDER;
                            pend_status_next = ST_UNDER;
                        end
                        else
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_rdata - SYM_W'(1);
                            rc_next    = rc_inc;
                        end
                    end
                    SYM_PUT:
                    begin
                        pend_ov_next = 1'b1;
                        pend_ob_next = tape_rdata;
                        rc_next      = rc_inc;
                    end
                    SYM_GET:
                    begin
                        if (inval_reg[INVAL_W-1:SYM_W] != '0)
                        begin
                            latched_next     = ST_BADIN;
                            pend_status_next = ST_BADIN;
                        end
                        else
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = inval_reg[SYM_W-1:0];
                            rc_next    = rc_inc;
                        end
                    end
                    SYM_OPEN,
                    SYM_CLOSE:
                    begin
                        if (need_scan)
                        begin
                            scan_pos_next   = rc_reg[PA_W-1:0];
                            scan_depth_next = '0;
                            scan_fwd_next   = (prog_rdata == SYM_OPEN);
                        end
                        else
                        begin
                            rc_next = rc_inc;
                        end
                    end
                    default:
                    begin
                        rc_next = rc_inc;
                    end
                endcase
            end

            // move to the next symbol, or fail at the program edge
            OP_SCAN_ADDR:
            begin
                prog_raddr = scan_step;
                if (scan_end)
                begin
                    latched_next     = ST_BRACKET;
                    pend_status_next = ST_BRACKET;
                end
                else
                begin
                    scan_pos_next = scan_step;
                end
            end

            // partner found, or track nesting depth
            OP_SCAN_TEST:
            begin
                if (scan_hit)
                begin
                    rc_next = scan_pos_inc;
                end
                else if (prog_rdata == open_sym)
                begin
                    scan_depth_next = scan_depth_reg + LEN_W'(1);
                end
                else if (prog_rdata == close_sym)
                begin
                    scan_depth_next = scan_depth_reg - LEN_W'(1);
                end
            end

            // load the output register
            OP_PUBLISH:
            begin
                res_valid_next  = 1'b1;
                res_status_next = pend_status_reg;
                res_ov_next     = pend_ov_reg;
                res_ob_next     = pend_ob_reg;
                res_pc_next     = rc_wide[PC_OUT_W-1:0];
            end

            // zero one tape cell per cycle
            OP_CLEAR:
            begin
                tape_we      = 1'b1;
                tape_waddr   = clr_idx_reg;
                tape_wdata   = '0;
                clr_idx_next = clear_last ? '0 : (clr_idx_reg + PTR_W'(1));
            end

            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            parity_reg    <= 1'b0;
            ptr_reg       <= '0;
            rc_reg        <= '0;
            latched_reg   <= ST_OK;
            clr_idx_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            parity_reg    <= parity_next;
            ptr_reg       <= ptr_next;
            rc_reg        <= rc_next;
            latched_reg   <= latched_next;
            clr_idx_reg   <= clr_idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        sym_reg         <= sym_next;
        inval_reg       <= inval_next;
        scan_pos_reg    <= scan_pos_next;
        scan_depth_reg  <= scan_depth_next;
        scan_fwd_reg    <= scan_fwd_next;
        pend_status_reg <= pend_status_next;
        pend_ov_reg     <= pend_ov_next;
        pend_ob_reg     <= pend_ob_next;
        res_status_reg  <= res_status_next;
        res_ov_reg      <= res_ov_next;
        res_ob_reg      <= res_ob_next;
        res_pc_reg      <= res_pc_next;
    end

    assign res_valid       = res_valid_reg;
    assign status          = res_status_reg;
    assign out_valid       = res_ov_reg;
    assign out_byte        = res_ob_reg;
    assign program_counter = res_pc_reg;

endmodule

### tb/tape_interp_checker.sv
`timescale 1ns / 100ps
// scoreboard for the bounded tape interpreter: watches both channels, interprets requests, checks results
module tape_interp_checker #(
    parameter int TAPE_CELLS    = btic_pkg::TAPE_CELLS_DEF,
    parameter int PROGRAM_DEPTH = btic_pkg::PROGRAM_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [btic_pkg::REQ_W-1:0]    req_type,
    input  logic [btic_pkg::SYM_W-1:0]    program_symbol,
    input  logic [btic_pkg::INVAL_W-1:0]  in_value,
    input  logic                          res_valid,
    input  logic                          res_stall,
    input  logic [btic_pkg::STATUS_W-1:0] status,
    input  logic                          out_valid,
    input  logic [btic_pkg::SYM_W-1:0]    out_byte,
    input  logic [btic_pkg::PC_OUT_W-1:0] program_counter,
    output int                            fail_count,
    output int                            pending_count,
    output int                            checked_count,
    output int                            bytes_out_count,
    output logic [15:0]                   status_seen
);
    import btic_pkg::*;

    typedef struct packed {
        status_t             status;
        logic                out_valid;
        logic [SYM_W-1:0]    out_byte;
        logic [PC_OUT_W-1:0] pc;
    } tape_answer_t;

    // interpreter state kept beside the block
    logic [SYM_W-1:0] prog_mem [PROGRAM_DEPTH];
    logic [SYM_W-1:0] tape_mem [TAPE_CELLS];
    int               prog_len;
    int               run_pc;
    int               cell_ptr;
    bit               parity_odd;
    status_t          held_error;

    // answers owed by the block, oldest first
    tape_answer_t answers_due[$];

    initial
    begin
        foreach (prog_mem[i]) prog_mem[i] = '0;
        foreach (tape_mem[i]) tape_mem[i] = '0;
        prog_len        = 0;
        run_pc          = 0;
        cell_ptr        = 0;
        parity_odd      = 1'b0;
        held_error      = ST_OK;
        fail_count      = 0;
        pending_count   = 0;
        checked_count   = 0;
        bytes_out_count = 0;
        status_seen     = '0;
    end

    // walk the stored program for the partner of the bracket at origin
    function automatic bit seek_partner(int origin, bit forward, output int hit);
        int               level;
        int               k;
        bit               found;
        bit               done;
        logic [SYM_W-1:0] nests;
        logic [SYM_W-1:0] closes;
        level  = 0;
        k      = origin;
        found  = 1'b0;
        done   = 1'b0;
        hit    = 0;
        nests  = forward ? SYM_OPEN : SYM_CLOSE;
        closes = forward ? SYM_CLOSE : SYM_OPEN;
        while (!done)
        begin
            if (forward ? (k + 1 >= prog_len) : (k == 0))
            begin
                done = 1'b1;
            end
            else
            begin
                k = forward ? k + 1 : k - 1;
                if (prog_mem[k] == nests)
                begin
                    level++;
                end
                else if (prog_mem[k] == closes)
                begin
                    if (level == 0)
                    begin
                        hit   = k;
                        found = 1'b1;
                        done  = 1'b1;
                    end
                    else
                    begin
                        level--;
                    end
                end
            end
        end
        return found;
    endfunction

    // one execute request: bounded pointer and cells, errors latch
    function automatic status_t run_one(logic [INVAL_W-1:0] val, output logic ov,
                                        output logic [SYM_W-1:0] ob);
        status_t          verdict;
        int               nxt;
        int               target;
        logic [SYM_W-1:0] op;
        logic [SYM_W-1:0] cur;
        ov      = 1'b0;
        ob      = '0;
        verdict = ST_OK;
        if (held_error != ST_OK)
        begin
            verdict = ST_LATCHED;
        end
        else if (parity_odd)
        begin
            verdict = ST_BRACKET;
        end
        else if (run_pc >= prog_len)
        begin
            verdict = ST_ENDED;
        end
        else
        begin
            nxt = run_pc + 1;
            op  = prog_mem[run_pc];
            cur = tape_mem[cell_ptr];
            case (op)
                SYM_RIGHT:
                begin
                    if (cell_ptr >= TAPE_CELLS - 1) verdict = ST_ABOVE;
                    else cell_ptr++;
                end
                SYM_LEFT:
                begin
                    if (cell_ptr == 0) verdict = ST_BELOW;
                    else cell_ptr--;
                end
                SYM_INC:
                begin
                    if (cur == CELL_MAX) verdict = ST_OVER;
                    else tape_mem[cell_ptr] = cur + 1'b1;
                end
                SYM_DEC:
                begin
                    if (cur == '0) verdict = ST_UNDER;
                    else tape_mem[cell_ptr] = cur - 1'b1;
                end
                SYM_PUT:
                begin
                    ov = 1'b1;
                    ob = cur;
                end
                SYM_GET:
                begin
                    if (val > CELL_MAX) verdict = ST_BADIN;
                    else tape_mem[cell_ptr] = val[SYM_W-1:0];
                end
                SYM_OPEN:
                begin
                    if (cur == '0)
                    begin
                        if (seek_partner(run_pc, 1'b1, target)) nxt = target + 1;
                        else verdict = ST_BRACKET;
                    end
                end
                SYM_CLOSE:
                begin
                    if (cur != '0)
                    begin
                        if (seek_partner(run_pc, 1'b0, target)) nxt = target + 1;
                        else verdict = ST_BRACKET;
                    end
                end
                default:
                begin
                end
            endcase
            if (verdict == ST_OK) run_pc = nxt;
        end
        if (verdict != ST_OK && verdict != ST_LATCHED && verdict != ST_ENDED)
            held_error = verdict;
        return verdict;
    endfunction

    // answer owed for one request transfer
    function automatic tape_answer_t interpret_request(req_t kind, logic [SYM_W-1:0] sym,
                                                       logic [INVAL_W-1:0] val);
        tape_answer_t ans;
        logic         ov;
        logic [SYM_W-1:0] ob;
        ans = '0;
        case (kind)
            REQ_LOAD:
            begin
                if (prog_len >= PROGRAM_DEPTH)
                begin
                    ans.status = ST_FULL;
                end
                else
                begin
                    prog_mem[prog_len] = sym;
                    prog_len++;
                    if (sym == SYM_OPEN || sym == SYM_CLOSE) parity_odd = !parity_odd;
                end
            end
            REQ_STEP:
            begin
                ans.status    = run_one(val, ov, ob);
                ans.out_valid = ov;
                ans.out_byte  = ob;
            end
            REQ_RESTART:
            begin
                foreach (tape_mem[i]) tape_mem[i] = '0;
                cell_ptr   = 0;
                run_pc     = 0;
                held_error = ST_OK;
            end
            default:
            begin
                prog_len   = 0;
                parity_odd = 1'b0;
                run_pc     = 0;
            end
        endcase
        ans.pc = run_pc[PC_OUT_W-1:0];
        return ans;
    endfunction

    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            fail_count++;
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        end
    endfunction

    // result transfers are checked before the request taken at the same edge is queued
    always @(posedge clk)
    begin : watch_channels
        tape_answer_t due;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                checked_count++;
                if (!$isunknown(status)) status_seen[status] = 1'b1;
                if (out_valid === 1'b1) bytes_out_count++;
                if (answers_due.size() == 0)
                begin
                    fail_count++;
                    $error("result transfer with no request outstanding: status %0d", status);
                end
                else
                begin
                    due = answers_due.pop_front();
                    compare_field("status", 16'(due.status), 16'(status));
                    compare_field("out_valid", 16'(due.out_valid), 16'(out_valid));
                    compare_field("out_byte", 16'(due.out_byte), 16'(out_byte));
                    compare_field("program_counter", 16'(due.pc), 16'(program_counter));
                end
            end
            if (in_valid && !in_stall)
                answers_due.push_back(interpret_request(req_t'(req_type), program_symbol,
                                                        in_value));
            pending_count = answers_due.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// stimulus, receiver stalls, watchdog and verdict for the bounded tape interpreter core
module tb_top;
    import btic_pkg::*;

    localparam int TAPE         = TAPE_CELLS_DEF;
    localparam int DEPTH        = PROGRAM_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 300;
    localparam int QUIET_LIMIT  = 20000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 300;

    logic                clk;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    req_t                req_type       = REQ_LOAD;
    logic [SYM_W-1:0]    program_symbol = '0;
    logic [INVAL_W-1:0]  in_value       = '0;
    logic                res_valid;
    logic                res_stall      = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                out_valid;
    logic [SYM_W-1:0]    out_byte;
    logic [PC_OUT_W-1:0] program_counter;

    int          fail_count;
    int          pending_count;
    int          checked_count;
    int          bytes_out_count;
    logic [15:0] status_seen;

    int sent_count    = 0;
    int send_idle_pct = 36;
    int recv_idle_pct = 56;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    bounded_tape_interpreter_core #(
        .TAPE_CELLS    (TAPE),
        .PROGRAM_DEPTH (DEPTH)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .program_symbol  (program_symbol),
        .in_value        (in_value),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status          (status),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .program_counter (program_counter)
    );

    tape_interp_checker #(
        .TAPE_CELLS    (TAPE),
        .PROGRAM_DEPTH (DEPTH)
    ) scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .program_symbol  (program_symbol),
        .in_value        (in_value),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status          (status),
        .out_valid       (out_valid),
        .out_byte        (out_byte),
        .program_counter (program_counter),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .checked_count   (checked_count),
        .bytes_out_count (bytes_out_count),
        .status_seen     (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, or a long hold-off counted down here
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (res_valid && !res_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL bounded_tape_interpreter_core");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one request after a random gap, hold it until the transfer
    task automatic send_request(req_t kind, logic [SYM_W-1:0] sym, logic [INVAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= kind;
        program_symbol <= sym;
        in_value       <= val;
        do
            @(posedge clk);
        while (in_stall);
        sent_count++;
    endtask

    // stop offering until every owed result has come back
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    // mostly command symbols, brackets nested at most three deep and closed in time
    function automatic logic [SYM_W-1:0] pick_symbol(inout int depth, input int left);
        int               roll;
        logic [SYM_W-1:0] pick;
        roll = $urandom_range(99);
        if (depth > 0 && (left <= depth || roll < 10))
        begin
            depth--;
            pick = SYM_CLOSE;
        end
        else if (depth < 3 && left > depth + 2 && roll < 22)
        begin
            depth++;
            pick = SYM_OPEN;
        end
        else if (roll < 45) pick = SYM_INC;
        else if (roll < 57) pick = SYM_RIGHT;
        else if (roll < 65) pick = SYM_LEFT;
        else if (roll < 74) pick = SYM_DEC;
        else if (roll < 84) pick = SYM_PUT;
        else if (roll < 94) pick = SYM_GET;
        else pick = 8'($urandom);
        return pick;
    endfunction

    // load a short program and run it, with noise bursts and broken bracket sets now and then
    task automatic random_episode();
        int               len;
        int               depth;
        int               roll;
        bit               broken;
        logic [SYM_W-1:0] stray;
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            repeat ($urandom_range(1, 6))
                send_request(req_t'($urandom_range(3)), 8'($urandom), 16'($urandom));
        end
        else
        begin
            send_request(REQ_ERASE, 8'($urandom), 16'($urandom));
            if (roll < 85) send_request(REQ_RESTART, 8'($urandom), 16'($urandom));
            broken = ($urandom_range(9) == 0);
            stray  = $urandom_range(1) ? SYM_OPEN : SYM_CLOSE;
            if (broken) send_request(REQ_LOAD, stray, 16'($urandom));
            len   = $urandom_range(1, 24);
            depth = 0;
            for (int i = 0; i < len; i++)
                send_request(REQ_LOAD, pick_symbol(depth, len - i), 16'($urandom));
            // a trailing partner of the other kind evens the count; it pairs only with a leading open
            if (broken && $urandom_range(1))
                send_request(REQ_LOAD, (stray == SYM_OPEN) ? SYM_CLOSE : SYM_OPEN,
                             16'($urandom));
            repeat ($urandom_range(len, 3 * len + 4))
            begin
                roll = $urandom_range(99);
                if (roll < 3)
                    send_request(REQ_RESTART, 8'($urandom), 16'($urandom));
                else if (roll < 6)
                    send_request(REQ_LOAD, pick_symbol(depth, 1), 16'($urandom));
                else
                    send_request(REQ_STEP, 8'($urandom),
                                 ($urandom_range(19) == 0) ? 16'($urandom)
                                                           : 16'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        int               phase;
        int               base;
        int               goal;
        int               fill_items;
        int               mark;
        logic [SYM_W-1:0] filler;
        fill_items = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty program, error latch, odd and unmatched brackets, cell limits
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_LOAD, SYM_DEC, 16'hFFFF);
        send_request(REQ_STEP, 8'hFF, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_LOAD, SYM_OPEN, 16'h0000);
        send_request(REQ_RESTART, 8'h00, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_ERASE, 8'h00, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_RESTART, 8'h00, 16'h0000);
        send_request(REQ_LOAD, SYM_CLOSE, 16'h0000);
        send_request(REQ_LOAD, SYM_OPEN, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_RESTART, 8'h00, 16'h0000);
        send_request(REQ_ERASE, 8'h00, 16'h0000);
        send_request(REQ_LOAD, SYM_LEFT, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_RESTART, 8'h00, 16'h0000);
        send_request(REQ_ERASE, 8'h00, 16'h0000);
        send_request(REQ_LOAD, SYM_GET, 16'h0000);
        send_request(REQ_LOAD, SYM_PUT, 16'h0000);
        send_request(REQ_LOAD, SYM_INC, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'h00FF);
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'h0000);
        send_request(REQ_RESTART, 8'h00, 16'h0000);
        send_request(REQ_STEP, 8'h00, 16'hFFFF);
        send_request(REQ_RESTART, 8'h00, 16'h0000);
        drain();
        base = sent_count;

        // random: three idling regimes, each ending in a full drain
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 36;
                    recv_idle_pct = 56;
                    hold_left     = LONG_HOLD;
                end
                1:
                begin
                    send_idle_pct = 56;
                    recv_idle_pct = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            goal = base + (phase + 1) * RANDOM_ITEMS / 3 + fill_items;
            while (sent_count < goal) random_episode();
            if (phase == 1)
            begin
                // whole store: long forward jump, store full, pointer run off the top
                mark = sent_count;
                send_request(REQ_ERASE, 8'($urandom), 16'($urandom));
                send_request(REQ_LOAD, SYM_GET, 16'($urandom));
                send_request(REQ_LOAD, SYM_OPEN, 16'($urandom));
                for (int i = 2; i < DEPTH - 2; i++)
                begin
                    filler = SYM_RIGHT;
                    if (i > TAPE + 8)
                    begin
                        do
                            filler = 8'($urandom);
                        while (filler == SYM_OPEN || filler == SYM_CLOSE);
                    end
                    send_request(REQ_LOAD, filler, 16'($urandom));
                end
                send_request(REQ_LOAD, SYM_CLOSE, 16'($urandom));
                send_request(REQ_LOAD, SYM_PUT, 16'($urandom));
                repeat (2) send_request(REQ_LOAD, 8'($urandom), 16'($urandom));
                send_request(REQ_RESTART, 8'($urandom), 16'($urandom));
                send_request(REQ_STEP, 8'($urandom), 16'h0000);
                repeat (3) send_request(REQ_STEP, 8'($urandom), 16'($urandom));
                send_request(REQ_RESTART, 8'($urandom), 16'($urandom));
                send_request(REQ_STEP, 8'($urandom), 16'h0007);
                repeat (TAPE + 2) send_request(REQ_STEP, 8'($urandom), 16'($urandom));
                send_request(REQ_RESTART, 8'($urandom), 16'($urandom));
                fill_items = sent_count - mark;
            end
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        $display("run covered %0d requests and %0d checked results, %0d with an output byte",
                 sent_count, checked_count, bytes_out_count);
        $display("status codes seen, one bit per code from 9 down to 0: %b", status_seen[9:0]);
        if (fail_count == 0 && pending_count == 0)
        begin
            $display("PASS bounded_tape_interpreter_core");
        end
        else
        begin
            if (pending_count != 0) $error("%0d results never arrived", pending_count);
            $display("FAIL bounded_tape_interpreter_core");
        end
        $finish;
    end

endmodule
